[src/god_pkg.sv]
// shared types, constants and functions for the gradient orientation difference core
`default_nettype none
package god_pkg;
   localparam int MaxDimDefault = 4096;
   localparam int CordicStagesDefault = 16;
   localparam int CountBitsDefault = 24;
   localparam int TableLen = 24;
   localparam int CordicFrac = 24;
   localparam int VecBits = 36;
   localparam int AngBits = 20;
   localparam int SumBits = 40;
   localparam int OutCountBits = 24;
   localparam int DimBits = 13;

   localparam logic CSR_IMAGE_ROWS = 1'b0;
   localparam logic CSR_IMAGE_COLS = 1'b1;

   typedef struct packed {
      logic [11:0] pixel_row;
      logic [11:0] pixel_col;
      logic [7:0]  src_center;
      logic [7:0]  src_right;
      logic [7:0]  src_below;
      logic [7:0]  dst_center;
      logic [7:0]  dst_right;
      logic [7:0]  dst_below;
      logic        last_pixel;
   } req_type;

   typedef struct packed {
      logic [15:0] mean_difference;
      logic [23:0] used_count;
      logic        no_pixels;
   } rsp_type;

   typedef struct packed {
      logic signed [VecBits-1:0] x;
      logic signed [VecBits-1:0] y;
      logic signed [AngBits-1:0] z;
      logic                      zero;
   } vec_type;

   function automatic logic signed [AngBits-1:0] atan_entry(input int i);
      logic signed [AngBits-1:0] r;
      case (i)
         0: r = 20'sd8192;
         1: r = 20'sd4836;
         2: r = 20'sd2555;
         3: r = 20'sd1297;
         4: r = 20'sd651;
         5: r = 20'sd326;
         6: r = 20'sd163;
         7: r = 20'sd81;
         8: r = 20'sd41;
         9: r = 20'sd20;
         10: r = 20'sd10;
         11: r = 20'sd5;
         12: r = 20'sd3;
         13: r = 20'sd1;
         14: r = 20'sd1;
         default: r = '0;
      endcase
      return r;
   endfunction
endpackage
`default_nettype wire

[src/god_cordic_cell.sv]
// one vectoring cordic micro-rotation with its pipeline register
`default_nettype none
module god_cordic_cell import god_pkg::*; #(
   parameter int SHIFT = 0
) (
   input  wire logic    clock,
   input  wire logic    en,
   input  wire vec_type vin,
   output vec_type      vout
);
   vec_type vout_ff, vout_in;
   logic signed [VecBits-1:0] xs, ys;
   always_comb begin
      // arithmetic shift is a floor shift
      xs = vin.x >>> SHIFT;
      ys = vin.y >>> SHIFT;
      vout_in = vin;
      if (!vin.y[VecBits-1]) begin
         vout_in.x = vin.x + ys;
         vout_in.y = vin.y - xs;
         vout_in.z = vin.z + atan_entry(SHIFT);
      end else begin
         vout_in.x = vin.x - ys;
         vout_in.y = vin.y + xs;
         vout_in.z = vin.z - atan_entry(SHIFT);
      end
   end
   always_ff @(posedge clock) begin
      if (en) vout_ff <= vout_in;
   end
   assign vout = vout_ff;
endmodule
`default_nettype wire

[src/god_cordic_chain.sv]
// pre-rotation and a row of cordic cells giving one binary angle
`default_nettype none
module god_cordic_chain import god_pkg::*; #(
   parameter int STAGES = 16
) (
   input  wire logic       clock,
   input  wire logic       en,
   input  wire logic [8:0] gx,
   input  wire logic [8:0] gy,
   output logic signed [AngBits-1:0] angle
);
   localparam int N = (STAGES > TableLen) ? TableLen : STAGES;
   vec_type v [N+1];
   logic signed [VecBits-1:0] x0, y0;
   always_comb begin
      x0 = {{(VecBits-9-CordicFrac){gx[8]}}, gx, {CordicFrac{1'b0}}};
      y0 = {{(VecBits-9-CordicFrac){gy[8]}}, gy, {CordicFrac{1'b0}}};
      v[0].zero = (gx == '0) && (gy == '0);
      v[0].x = x0;
      v[0].y = y0;
      v[0].z = '0;
      if (x0[VecBits-1]) begin
         if (!y0[VecBits-1]) begin
            v[0].x = y0;
            v[0].y = -x0;
            v[0].z = 20'sd16384;
         end else begin
            v[0].x = -y0;
            v[0].y = x0;
            v[0].z = -20'sd16384;
         end
      end
   end
   for (genvar i = 0; i < N; i++) begin : g_cell
      god_cordic_cell #(.SHIFT(i)) u_cell (
         .clock(clock), .en(en), .vin(v[i]), .vout(v[i+1])
      );
   end
   always_comb begin
      angle = v[N].z;
      if (v[N].zero) angle = '0;
      else if (v[N].z > 20'sd32768) angle = 20'sd32768;
      else if (v[N].z < -20'sd32768) angle = -20'sd32768;
   end
endmodule
`default_nettype wire

[src/god_divider.sv]
// restoring divider for the rounded mean, one quotient bit per cycle
`default_nettype none
module god_divider import god_pkg::*; #(
   parameter int COUNT_BITS = 24
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   input  wire logic [SumBits:0] dividend,
   input  wire logic [COUNT_BITS-1:0] divisor,
   output logic busy,
   output logic done,
   output logic [SumBits:0] quotient
);
   localparam int QB = SumBits + 1;
   localparam int CB = $clog2(QB + 1);
   logic [QB-1:0] q_ff, q_in;
   logic [COUNT_BITS:0] r_ff, r_in;
   logic [COUNT_BITS-1:0] d_ff;
   logic [CB-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic [COUNT_BITS+1:0] trial;
   always_comb begin
      q_in = q_ff; r_in = r_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; done_in = 1'b0;
      trial = {r_ff, q_ff[QB-1]};
      if (start) begin
         q_in = dividend; r_in = '0; cnt_in = CB'(QB); busy_in = 1'b1;
      end else if (busy_ff) begin
         q_in = {q_ff[QB-2:0], 1'b0};
         if (trial >= {2'b00, d_ff}) begin
            r_in = (COUNT_BITS+1)'(trial - {2'b00, d_ff});
            q_in[0] = 1'b1;
         end else begin
            r_in = trial[COUNT_BITS:0];
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CB'(1)) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; cnt_ff <= cnt_in;
      end
      q_ff <= q_in; r_ff <= r_in;
      if (start) d_ff <= divisor;
   end
   assign busy = busy_ff;
   assign done = done_ff;
   assign quotient = q_ff;
endmodule
`default_nettype wire

[src/gradient_orientation_difference_core.sv]
// top level: mean gradient orientation difference over a stream of region pixels
// usage:
//   req channel carries one region pixel per transaction (valid/stall).
//   rsp channel carries one result after a transaction with last_pixel set.
//   csr port writes image_rows (index 0) and image_cols (index 1) while idle.
// pipeline and intake:
//   a pixel runs through CORDIC_STAGES cordic cells (capped at the table length),
//   one register each, for both images side by side, and is summed at the
//   following edge. pixels enter back to back at one per cycle while no last
//   pixel is in flight. a last pixel stops intake until the result is taken.
//   the divider loads at the summing edge and works out the quotient bit by
//   bit; the output register then takes the result (at the summing edge
//   itself when no pixel was used), and the next pixel may enter in the cycle
//   after the result leaves.
// reset:
//   synchronous, clears sums, counts, in-flight valids and sets both
//   dimensions to 4096.
// stall:
//   a result holds in the output register while rsp_stall is high; intake
//   stays closed until it leaves.
`default_nettype none
module gradient_orientation_difference_core import god_pkg::*; #(
   parameter int MAX_DIM = MaxDimDefault,
   parameter int CORDIC_STAGES = CordicStagesDefault,
   parameter int COUNT_BITS = CountBitsDefault
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data,
   input  wire logic    csr_write,
   input  wire logic    csr_index,
   input  wire logic [DimBits-1:0] csr_data
);
   localparam int N = (CORDIC_STAGES > TableLen) ? TableLen : CORDIC_STAGES;
   localparam logic [COUNT_BITS-1:0] CountMax = '1;
   localparam logic [31:0] MaxDimW = 32'(MAX_DIM);

   logic [DimBits-1:0] rows_ff, cols_ff;
   logic [DimBits-1:0] csr_clip;
   always_comb begin
      csr_clip = csr_data;
      if ({{(32-DimBits){1'b0}}, csr_data} > MaxDimW) csr_clip = DimBits'(MAX_DIM);
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= DimBits'(4096); cols_ff <= DimBits'(4096);
      end else if (csr_write) begin
         case (csr_index)
            CSR_IMAGE_ROWS: rows_ff <= csr_clip;
            CSR_IMAGE_COLS: cols_ff <= csr_clip;
            default: ;
         endcase
      end
   end

   // pipeline control: blocked from a last pixel's acceptance until its result leaves
   logic busy_ff, busy_in;
   logic accept;
   assign req_stall = busy_ff;
   assign accept = req_valid && !busy_ff;

   // one flag stage per cordic register
   logic [N-1:0] vld_ff, keep_ff, last_ff;
   logic keep_now;
   always_comb begin
      keep_now = ({1'b0, req_data.pixel_row} + 13'd1 < rows_ff)
              && ({1'b0, req_data.pixel_col} + 13'd1 < cols_ff)
              && (req_data.src_right != '0) && (req_data.src_below != '0);
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[N-2:0], accept};
      end
      keep_ff <= {keep_ff[N-2:0], keep_now};
      last_ff <= {last_ff[N-2:0], req_data.last_pixel};
   end

   logic [8:0] sgx, sgy, dgx, dgy;
   assign sgx = {1'b0, req_data.src_center} - {1'b0, req_data.src_right};
   assign sgy = {1'b0, req_data.src_center} - {1'b0, req_data.src_below};
   assign dgx = {1'b0, req_data.dst_center} - {1'b0, req_data.dst_right};
   assign dgy = {1'b0, req_data.dst_center} - {1'b0, req_data.dst_below};

   logic signed [AngBits-1:0] a1, a2;
   god_cordic_chain #(.STAGES(N)) u_src (
      .clock(clock), .en(1'b1), .gx(sgx), .gy(sgy), .angle(a1)
   );
   god_cordic_chain #(.STAGES(N)) u_dst (
      .clock(clock), .en(1'b1), .gx(dgx), .gy(dgy), .angle(a2)
   );

   // accumulate at the chain output
   logic [SumBits-1:0] sum_ff, sum_in;
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in;
   logic [AngBits-1:0] diff;
   logic [15:0] dclip;
   logic [SumBits:0] sum_wide;
   logic out_vld, out_keep, out_last;
   logic div_start;
   logic [SumBits-1:0] fin_sum;
   logic [COUNT_BITS-1:0] fin_cnt;
   assign out_vld = vld_ff[N-1];
   assign out_keep = keep_ff[N-1];
   assign out_last = last_ff[N-1];
   always_comb begin
      diff = (a1 > a2) ? AngBits'(a1 - a2) : AngBits'(a2 - a1);
      dclip = (diff > 20'd65535) ? 16'hFFFF : diff[15:0];
      sum_in = sum_ff; cnt_in = cnt_ff;
      fin_sum = sum_ff; fin_cnt = cnt_ff;
      sum_wide = {1'b0, sum_ff} + (SumBits+1)'(dclip);
      if (out_vld && out_keep && cnt_ff != CountMax) begin
         sum_in = sum_wide[SumBits] ? '1 : sum_wide[SumBits-1:0];
         cnt_in = cnt_ff + 1'b1;
         fin_sum = sum_in; fin_cnt = cnt_in;
      end
      div_start = out_vld && out_last;
      if (div_start) begin
         sum_in = '0; cnt_in = '0;
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0; cnt_ff <= '0;
      end else begin
         sum_ff <= sum_in; cnt_ff <= cnt_in;
      end
   end

   logic [COUNT_BITS-1:0] hold_cnt_ff;
   logic [SumBits:0] dividend;
   logic div_busy, div_done;
   logic [SumBits:0] quotient;
   assign dividend = {1'b0, fin_sum} + (SumBits+1)'(fin_cnt >> 1);
   always_ff @(posedge clock) begin
      if (div_start) hold_cnt_ff <= fin_cnt;
   end
   god_divider #(.COUNT_BITS(COUNT_BITS)) u_div (
      .clock(clock), .reset(reset), .start(div_start && fin_cnt != '0),
      .dividend(dividend), .divisor(fin_cnt),
      .busy(div_busy), .done(div_done), .quotient(quotient)
   );

   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in = rsp_ff;
      busy_in = busy_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0; busy_in = 1'b0;
      end
      if (accept && req_data.last_pixel) busy_in = 1'b1;
      if (div_start && fin_cnt == '0) begin
         rsp_valid_in = 1'b1;
         rsp_in.mean_difference = '0;
         rsp_in.used_count = '0;
         rsp_in.no_pixels = 1'b1;
      end else if (div_done) begin
         rsp_valid_in = 1'b1;
         rsp_in.mean_difference = (quotient > 41'd65535) ? 16'hFFFF : quotient[15:0];
         if (COUNT_BITS > OutCountBits && (hold_cnt_ff >> OutCountBits) != '0)
            rsp_in.used_count = '1;
         else
            rsp_in.used_count = OutCountBits'(hold_cnt_ff);
         rsp_in.no_pixels = 1'b0;
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0; busy_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in; busy_ff <= busy_in;
      end
      rsp_ff <= rsp_in;
   end
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   a_no_intake_while_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> req_stall) else $error("intake open while result pending");
   a_div_idle_at_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !div_busy) else $error("divider busy with result shown");
   a_start_cleared: assert property (@(posedge clock) disable iff (reset)
      div_start |=> (cnt_ff == '0 && sum_ff == '0)) else $error("sums not cleared");
endmodule
`default_nettype wire
